### sv/arc_pkg.sv
// Shared types and constants for the adaptive retransmit controller.
// No dependencies; used by every module of the block.
`default_nettype none
package arc_pkg;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] RstInitialTimeout    = 16'd2;
  localparam logic [15:0] RstMaxTimeout        = 16'd32;
  localparam logic [7:0]  RstMaxRepeats        = 8'd3;
  localparam logic [7:0]  RstChecksumFailLimit = 8'd20;
  localparam logic [15:0] AdaptMargin          = 16'd2;

  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_TIMEOUT  = 2'd1,
    CMD_RESPONSE = 2'd2,
    CMD_NOP      = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ACT_SEND          = 3'd0,
    ACT_WAIT          = 3'd1,
    ACT_ACCEPT        = 3'd2,
    ACT_UNREACHABLE   = 3'd3,
    ACT_CHECKSUM_FAIL = 3'd4
  } action_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_INITIAL_TIMEOUT     = 2'd0,
    REG_MAX_TIMEOUT         = 2'd1,
    REG_MAX_REPEATS         = 2'd2,
    REG_CHECKSUM_FAIL_LIMIT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] elapsed_seconds;
    logic [15:0] response_sequence;
    logic        checksum_ok;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] timeout_value;
    logic [15:0] request_sequence;
  } out_item_t;

  typedef struct packed {
    logic [15:0] initial_timeout;
    logic [15:0] max_timeout;
    logic [7:0]  max_repeats;
    logic [7:0]  checksum_fail_limit;
  } cfg_t;

endpackage
`default_nettype wire

### sv/adaptive_retransmit_controller.sv
// Top level of the adaptive retransmit controller: input register, engine,
// result register. Depends on arc_pkg, arc_cfg_regs and arc_engine.
//
//   channel | ports                          | dir | transfer
//   --------+--------------------------------+-----+-----------------------
//   input   | in_valid, in_ready, in_data    | in  | valid & ready at clk
//   result  | out_valid, out_ready, out_data | out | valid & ready at clk
//   config  | cfg_we, cfg_addr, cfg_wdata    | in  | cfg_we at clk
//
// An event is held in the input register, then the engine decides and the
// result register captures the answer: out_valid rises when the event moves
// on into the result register; one transaction per cycle sustained while
// out_ready stays high. The engine state updates in the same cycle the
// result is captured, so back-to-back events chain.
// A stalled out_ready holds the result and the queued event; in_ready falls
// only when both stages are full. Reset (rst_n low, synchronous) empties both
// stages and loads the register and state reset values.
`default_nettype none
module adaptive_retransmit_controller (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire arc_pkg::in_item_t            in_data,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output arc_pkg::out_item_t                out_data,
  input  wire logic                         cfg_we,
  input  wire logic [arc_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [arc_pkg::CfgDataW-1:0] cfg_wdata
);

  arc_pkg::cfg_t      cfg;
  arc_pkg::in_item_t  in_item_r;
  logic               in_valid_r;
  arc_pkg::out_item_t out_item_r;
  logic               out_valid_r;
  arc_pkg::out_item_t result;
  logic               advance;

  arc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // event moves from the input register into the result register
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  arc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

### sv/arc_cfg_regs.sv
// Configuration register file of the retransmit controller.
// Depends on arc_pkg.
`default_nettype none
module arc_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [arc_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [arc_pkg::CfgDataW-1:0] cfg_wdata,
  output arc_pkg::cfg_t                     cfg
);

  arc_pkg::cfg_t cfg_r;
  arc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (arc_pkg::reg_index_t'(cfg_addr))
        arc_pkg::REG_INITIAL_TIMEOUT:     cfg_nxt.initial_timeout     = cfg_wdata;
        arc_pkg::REG_MAX_TIMEOUT:         cfg_nxt.max_timeout         = cfg_wdata;
        arc_pkg::REG_MAX_REPEATS:         cfg_nxt.max_repeats         = cfg_wdata[7:0];
        arc_pkg::REG_CHECKSUM_FAIL_LIMIT: cfg_nxt.checksum_fail_limit = cfg_wdata[7:0];
        default:                          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_timeout     <= arc_pkg::RstInitialTimeout;
      cfg_r.max_timeout         <= arc_pkg::RstMaxTimeout;
      cfg_r.max_repeats         <= arc_pkg::RstMaxRepeats;
      cfg_r.checksum_fail_limit <= arc_pkg::RstChecksumFailLimit;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### sv/arc_engine.sv
// Protocol state (timeout, repeat and checksum counters, sequence number)
// and the per-transaction decision logic. Depends on arc_pkg.
`default_nettype none
module arc_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire arc_pkg::in_item_t  item,
  input  wire arc_pkg::cfg_t      cfg,
  output arc_pkg::out_item_t      result
);

  logic [15:0] timeout_r, timeout_nxt;
  logic [7:0]  repeat_r, repeat_nxt;
  logic [7:0]  bad_r, bad_nxt;
  logic [15:0] seq_r, seq_nxt;
  arc_pkg::action_t action;

  logic [15:0] doubled;
  logic [15:0] elapsed_eff;
  logic [15:0] elapsed_dbl;
  logic [15:0] adapted;
  logic [15:0] slack;

  always_comb begin
    doubled     = timeout_r[15] ? 16'hFFFF : {timeout_r[14:0], 1'b0};
    elapsed_eff = (item.elapsed_seconds == 16'd0) ? 16'd1 : item.elapsed_seconds;
    elapsed_dbl = elapsed_eff[15] ? 16'hFFFF : {elapsed_eff[14:0], 1'b0};
    slack       = timeout_r - elapsed_eff;
    if (elapsed_eff > timeout_r) begin
      adapted = elapsed_dbl;
    end else if (slack > arc_pkg::AdaptMargin) begin
      adapted = elapsed_eff + arc_pkg::AdaptMargin;
    end else begin
      adapted = timeout_r;
    end
  end

  always_comb begin
    timeout_nxt = timeout_r;
    repeat_nxt  = repeat_r;
    bad_nxt     = bad_r;
    seq_nxt     = seq_r;
    action      = arc_pkg::ACT_WAIT;
    unique case (arc_pkg::command_t'(item.command))
      arc_pkg::CMD_START: begin
        seq_nxt = seq_r + 16'd1;
        action  = arc_pkg::ACT_SEND;
      end
      arc_pkg::CMD_TIMEOUT: begin
        if (repeat_r < cfg.max_repeats) begin
          repeat_nxt = repeat_r + 8'd1;
          action     = arc_pkg::ACT_SEND;
        end else begin
          repeat_nxt = 8'd0;
          if (timeout_r >= cfg.max_timeout) begin
            timeout_nxt = cfg.initial_timeout;
            action      = arc_pkg::ACT_UNREACHABLE;
          end else begin
            timeout_nxt = doubled;
            action      = arc_pkg::ACT_SEND;
          end
        end
      end
      arc_pkg::CMD_RESPONSE: begin
        timeout_nxt = adapted;
        if (!item.checksum_ok) begin
          if (bad_r > cfg.checksum_fail_limit) begin
            bad_nxt = 8'd0;
            action  = arc_pkg::ACT_CHECKSUM_FAIL;
          end else begin
            bad_nxt = (bad_r == 8'hFF) ? bad_r : bad_r + 8'd1;
            action  = arc_pkg::ACT_SEND;
          end
        end else begin
          bad_nxt = 8'd0;
          action  = (item.response_sequence == seq_r) ? arc_pkg::ACT_ACCEPT
                                                       : arc_pkg::ACT_WAIT;
        end
      end
      default: begin
        action = arc_pkg::ACT_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= arc_pkg::RstInitialTimeout;
      repeat_r  <= 8'd0;
      bad_r     <= 8'd0;
      seq_r     <= 16'd0;
    end else if (advance) begin
      timeout_r <= timeout_nxt;
      repeat_r  <= repeat_nxt;
      bad_r     <= bad_nxt;
      seq_r     <= seq_nxt;
    end
  end

  always_comb begin
    result.action           = action;
    result.timeout_value    = timeout_nxt;
    result.request_sequence = seq_nxt;
  end

endmodule
`default_nettype wire
